// ===== hdl/aeg_pkg.sv =====
`timescale 1ns / 1ps

package aeg_pkg;

    // APB register map: eight registers at 8-byte strides
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic [2:0] REG_ATTACK_DUR  = 3'd0;
    localparam logic [2:0] REG_ATTACK_LVL  = 3'd1;
    localparam logic [2:0] REG_DECAY_DUR   = 3'd2;
    localparam logic [2:0] REG_SUSTAIN_LVL = 3'd3;
    localparam logic [2:0] REG_REL_START   = 3'd4;
    localparam logic [2:0] REG_REL_DUR     = 3'd5;
    localparam logic [2:0] REG_REL_INF     = 3'd6;
    localparam logic [2:0] REG_MASTER_VOL  = 3'd7;

    localparam logic [2:0] PH_ATTACK  = 3'd0;
    localparam logic [2:0] PH_DECAY   = 3'd1;
    localparam logic [2:0] PH_SUSTAIN = 3'd2;
    localparam logic [2:0] PH_RELEASE = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    // slice width of the shared multiplier's second operand
    localparam int MUL_CHUNK = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB,
        ST_DIFF,
        ST_PHASE,
        ST_MULE,
        ST_DLOAD,
        ST_DIV,
        ST_MULV,
        ST_MULS,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hdl/adsr_envelope_gain_unit.sv =====
// Sustain, completed and held release skip the divider; attack and ramped release form
// the gain by one multiply and a divide, decay by two multiplies and a divide (NCH =
// 16-bit slices per multiply, 3 at defaults). One item at a time; the next is taken
// in the cycle after the result is registered. Uses the shared 16-bit-slice multiplier
// and the one-bit-per-cycle divider. Synchronous active-low reset: control and
// configuration registers to reset values, release latch cleared; datapath not reset.
`timescale 1ns / 1ps

module adsr_envelope_gain_unit #(
    parameter int TIME_BITS      = 48,
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: sample_time, sample_in (zero pad to bytes)
    input  logic [((TIME_BITS+SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata,
    // output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: sample_out, envelope_gain (zero pad to bytes)
    output logic [((SAMPLE_BITS+GAIN_FRAC_BITS+4+7)/8)*8-1:0] o_m_tdata,
    // tuser: phase
    output logic [2:0]                    o_m_tuser,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aeg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [aeg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [aeg_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int GB   = GAIN_FRAC_BITS + 4;
    localparam int CH   = aeg_pkg::MUL_CHUNK;
    localparam int MA   = (GB > SAMPLE_BITS) ? GB : SAMPLE_BITS;
    localparam int BW   = (TIME_BITS > 2 * GB) ? TIME_BITS : 2 * GB;
    localparam int NCH  = (BW + CH - 1) / CH;
    localparam int BP   = NCH * CH;
    localparam int AW   = MA + BP;
    localparam int NW   = GB + TIME_BITS;
    localparam int PW   = SAMPLE_BITS + 2 * GB;
    localparam int SW   = PW + 1 - 2 * GAIN_FRAC_BITS;
    localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int OUTW = ((SAMPLE_BITS + GB + 7) / 8) * 8;

    // configuration registers
    logic [TIME_BITS-1:0] r_att_dur;
    logic [GB-1:0]        r_att_lvl;
    logic [TIME_BITS-1:0] r_dec_dur;
    logic [GB-1:0]        r_sus_lvl;
    logic [TIME_BITS-1:0] r_rel_start;
    logic [TIME_BITS-1:0] r_rel_dur;
    logic                 r_rel_inf;
    logic [GB-1:0]        r_vol;

    // sequencer and envelope state
    aeg_pkg::t_state      r_state;
    aeg_pkg::t_state      n_state;
    logic                 r_latched;
    logic [GB-1:0]        r_rfg;
    logic [GB-1:0]        r_prev;

    // per-item datapath
    logic [TIME_BITS-1:0] r_t;
    logic                 r_neg;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [TIME_BITS-1:0] r_ea;
    logic [TIME_BITS-1:0] r_er;
    logic                 r_lt_a;
    logic                 r_lt_rs;
    logic [TIME_BITS-1:0] r_dme;
    logic                 r_dme_b;
    logic [TIME_BITS-1:0] r_rme;
    logic                 r_rme_b;
    logic [2:0]           r_phase;
    logic [GB-1:0]        r_gain;
    logic                 r_dec;
    logic                 r_pass;
    logic [MA-1:0]        r_ma;
    logic [BP-1:0]        r_mb;
    logic [AW-1:0]        r_acc;
    logic [NW-1:0]        r_num;
    logic [CW-1:0]        r_cnt;
    logic [TIME_BITS-1:0] r_den;

    // output register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_smp;
    logic [GB-1:0]          r_out_gain;
    logic [2:0]             r_out_phase;

    logic [TIME_BITS-1:0]   w_in_time;
    logic [SAMPLE_BITS-1:0] w_in_smp;
    logic                   w_cfg_wr;
    logic [2:0]             w_cfg_idx;
    logic [CH-1:0]          w_chunk;
    logic [MA+CH-1:0]       w_prod;
    logic [AW-1:0]          w_acc_next;
    logic                   w_last;
    logic                   w_dec_ok;
    logic                   w_rel_ok;
    logic [2:0]             w_ph;
    logic                   w_ramp;
    logic [GB-1:0]          w_rfg;
    logic                   w_div_start;
    logic [NW-1:0]          w_div_num;
    aeg_pkg::t_div_stat     w_div_stat;
    logic [GB-1:0]          w_div_quot;
    logic [PW:0]            w_sum;
    logic [SW-1:0]          w_shift;
    logic [SW-1:0]          w_limit;
    logic [SW-1:0]          w_sat;
    logic [SAMPLE_BITS-1:0] w_res;
    logic                   w_out_free;

    assign w_in_time = i_s_tdata[TIME_BITS-1:0];
    assign w_in_smp  = i_s_tdata[TIME_BITS+SAMPLE_BITS-1:TIME_BITS];

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[5:3];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att_dur   <= '0;
            r_att_lvl   <= GB'(1) << GAIN_FRAC_BITS;
            r_dec_dur   <= '0;
            r_sus_lvl   <= GB'(1) << GAIN_FRAC_BITS;
            r_rel_start <= '0;
            r_rel_dur   <= '0;
            r_rel_inf   <= 1'b0;
            r_vol       <= GB'(1) << GAIN_FRAC_BITS;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                aeg_pkg::REG_ATTACK_DUR:  r_att_dur   <= pwdata[TIME_BITS-1:0];
                aeg_pkg::REG_ATTACK_LVL:  r_att_lvl   <= pwdata[GB-1:0];
                aeg_pkg::REG_DECAY_DUR:   r_dec_dur   <= pwdata[TIME_BITS-1:0];
                aeg_pkg::REG_SUSTAIN_LVL: r_sus_lvl   <= pwdata[GB-1:0];
                aeg_pkg::REG_REL_START:   r_rel_start <= pwdata[TIME_BITS-1:0];
                aeg_pkg::REG_REL_DUR:     r_rel_dur   <= pwdata[TIME_BITS-1:0];
                aeg_pkg::REG_REL_INF:     r_rel_inf   <= pwdata[0];
                aeg_pkg::REG_MASTER_VOL:  r_vol       <= pwdata[GB-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            aeg_pkg::REG_ATTACK_DUR:  prdata = aeg_pkg::APB_DATA_W'(r_att_dur);
            aeg_pkg::REG_ATTACK_LVL:  prdata = aeg_pkg::APB_DATA_W'(r_att_lvl);
            aeg_pkg::REG_DECAY_DUR:   prdata = aeg_pkg::APB_DATA_W'(r_dec_dur);
            aeg_pkg::REG_SUSTAIN_LVL: prdata = aeg_pkg::APB_DATA_W'(r_sus_lvl);
            aeg_pkg::REG_REL_START:   prdata = aeg_pkg::APB_DATA_W'(r_rel_start);
            aeg_pkg::REG_REL_DUR:     prdata = aeg_pkg::APB_DATA_W'(r_rel_dur);
            aeg_pkg::REG_REL_INF:     prdata = aeg_pkg::APB_DATA_W'(r_rel_inf);
            aeg_pkg::REG_MASTER_VOL:  prdata = aeg_pkg::APB_DATA_W'(r_vol);
        endcase
    end

    // ---------------- shared slice multiplier ----------------
    // MSB slice first: acc = (acc << CH) + a * slice
    assign w_chunk    = r_mb[BP-1 -: CH];
    assign w_prod     = (MA+CH)'(r_ma) * (MA+CH)'(w_chunk);
    assign w_acc_next = (r_acc << CH) + AW'(w_prod);
    assign w_last     = (r_cnt == CW'(NCH - 1));

    // ---------------- phase decision ----------------
    assign w_dec_ok = !r_dme_b && (r_dme != '0);
    assign w_rel_ok = r_rel_inf || (!r_rme_b && (r_rme != '0));
    assign w_rfg    = r_latched ? r_rfg : r_prev;

    always_comb begin
        priority if (r_lt_a) begin
            w_ph = aeg_pkg::PH_ATTACK;
        end else if (w_dec_ok) begin
            w_ph = aeg_pkg::PH_DECAY;
        end else if ((r_rel_start == '0) || r_lt_rs) begin
            w_ph = aeg_pkg::PH_SUSTAIN;
        end else if (w_rel_ok) begin
            w_ph = aeg_pkg::PH_RELEASE;
        end else begin
            w_ph = aeg_pkg::PH_DONE;
        end
    end

    assign w_ramp = (w_ph == aeg_pkg::PH_ATTACK) || (w_ph == aeg_pkg::PH_DECAY)
                 || ((w_ph == aeg_pkg::PH_RELEASE) && !r_rel_inf);

    // ---------------- divider ----------------
    assign w_div_start = (r_state == aeg_pkg::ST_DLOAD);
    assign w_div_num   = r_acc[NW-1:0] + r_num;

    aeg_divider #(
        .QUOT_BITS (GB),
        .DEN_BITS  (TIME_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_div_quot)
    );

    // ---------------- round and saturate ----------------
    assign w_sum   = (PW+1)'(r_acc[PW-1:0]) + ((PW+1)'(1) << (2 * GAIN_FRAC_BITS - 1));
    assign w_shift = w_sum[PW:2*GAIN_FRAC_BITS];
    assign w_limit = r_neg ? (SW'(1) << (SAMPLE_BITS - 1))
                           : ((SW'(1) << (SAMPLE_BITS - 1)) - SW'(1));
    assign w_sat   = (w_shift > w_limit) ? w_limit : w_shift;
    assign w_res   = r_neg ? (SAMPLE_BITS'(0) - w_sat[SAMPLE_BITS-1:0])
                           : w_sat[SAMPLE_BITS-1:0];

    assign w_out_free = !r_out_valid || i_m_tready;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aeg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aeg_pkg::ST_IDLE:  if (i_s_tvalid) n_state = aeg_pkg::ST_SUB;
            aeg_pkg::ST_SUB:   n_state = aeg_pkg::ST_DIFF;
            aeg_pkg::ST_DIFF:  n_state = aeg_pkg::ST_PHASE;
            aeg_pkg::ST_PHASE: n_state = w_ramp ? aeg_pkg::ST_MULE : aeg_pkg::ST_MULV;
            aeg_pkg::ST_MULE: begin
                if (w_last && (!r_dec || r_pass)) n_state = aeg_pkg::ST_DLOAD;
            end
            aeg_pkg::ST_DLOAD: n_state = aeg_pkg::ST_DIV;
            aeg_pkg::ST_DIV:   if (w_div_stat.done) n_state = aeg_pkg::ST_MULV;
            aeg_pkg::ST_MULV:  if (w_last) n_state = aeg_pkg::ST_MULS;
            aeg_pkg::ST_MULS:  if (w_last) n_state = aeg_pkg::ST_ROUND;
            aeg_pkg::ST_ROUND: if (w_out_free) n_state = aeg_pkg::ST_IDLE;
            default:           n_state = aeg_pkg::ST_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == aeg_pkg::ST_IDLE);

    // envelope state: release latch and previous gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= 1'b0;
            r_rfg     <= '0;
            r_prev    <= '0;
        end else begin
            if ((r_state == aeg_pkg::ST_PHASE) && (w_ph == aeg_pkg::PH_RELEASE)
                    && !r_latched) begin
                r_latched <= 1'b1;
                r_rfg     <= r_prev;
            end
            if ((r_state == aeg_pkg::ST_ROUND) && w_out_free) begin
                r_prev <= r_gain;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            aeg_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    r_t   <= w_in_time;
                    r_neg <= w_in_smp[SAMPLE_BITS-1];
                    r_mag <= w_in_smp[SAMPLE_BITS-1]
                           ? (SAMPLE_BITS'(0) - w_in_smp) : w_in_smp;
                end
            end
            aeg_pkg::ST_SUB: begin
                {r_lt_a, r_ea}  <= {1'b0, r_t} - {1'b0, r_att_dur};
                {r_lt_rs, r_er} <= {1'b0, r_t} - {1'b0, r_rel_start};
            end
            aeg_pkg::ST_DIFF: begin
                // borrow clear and nonzero means elapsed < duration
                {r_dme_b, r_dme} <= {1'b0, r_dec_dur} - {1'b0, r_ea};
                {r_rme_b, r_rme} <= {1'b0, r_rel_dur} - {1'b0, r_er};
            end
            aeg_pkg::ST_PHASE: begin
                r_phase <= w_ph;
                r_cnt   <= '0;
                r_acc   <= '0;
                r_pass  <= 1'b0;
                r_num   <= '0;
                r_dec   <= (w_ph == aeg_pkg::PH_DECAY);
                unique case (w_ph)
                    aeg_pkg::PH_ATTACK: begin
                        r_ma  <= MA'(r_att_lvl);
                        r_mb  <= BP'(r_t);
                        r_den <= r_att_dur;
                    end
                    aeg_pkg::PH_DECAY: begin
                        r_ma  <= MA'(r_sus_lvl);
                        r_mb  <= BP'(r_ea);
                        r_den <= r_dec_dur;
                    end
                    aeg_pkg::PH_SUSTAIN: begin
                        r_gain <= r_sus_lvl;
                        r_ma   <= MA'(r_sus_lvl);
                        r_mb   <= BP'(r_vol);
                    end
                    aeg_pkg::PH_RELEASE: begin
                        r_ma <= MA'(w_rfg);
                        if (r_rel_inf) begin
                            r_gain <= w_rfg;
                            r_mb   <= BP'(r_vol);
                        end else begin
                            r_mb  <= BP'(r_rme);
                            r_den <= r_rel_dur;
                        end
                    end
                    default: begin
                        r_gain <= '0;
                        r_ma   <= '0;
                        r_mb   <= BP'(r_vol);
                    end
                endcase
            end
            aeg_pkg::ST_MULE: begin
                r_acc <= w_acc_next;
                r_mb  <= r_mb << CH;
                r_cnt <= r_cnt + CW'(1);
                if (w_last) begin
                    r_cnt <= '0;
                    // decay: keep sustain*e, then form attack*(D-e)
                    if (r_dec && !r_pass) begin
                        r_num  <= w_acc_next[NW-1:0];
                        r_acc  <= '0;
                        r_ma   <= MA'(r_att_lvl);
                        r_mb   <= BP'(r_dme);
                        r_pass <= 1'b1;
                    end
                end
            end
            aeg_pkg::ST_DLOAD: begin
                r_acc <= '0;
            end
            aeg_pkg::ST_DIV: begin
                if (w_div_stat.done) begin
                    r_gain <= w_div_quot;
                    r_ma   <= MA'(w_div_quot);
                    r_mb   <= BP'(r_vol);
                    r_cnt  <= '0;
                end
            end
            aeg_pkg::ST_MULV: begin
                r_acc <= w_acc_next;
                r_mb  <= r_mb << CH;
                r_cnt <= r_cnt + CW'(1);
                if (w_last) begin
                    r_cnt <= '0;
                    r_acc <= '0;
                    r_ma  <= MA'(r_mag);
                    r_mb  <= BP'(w_acc_next[2*GB-1:0]);
                end
            end
            aeg_pkg::ST_MULS: begin
                r_acc <= w_acc_next;
                r_mb  <= r_mb << CH;
                r_cnt <= w_last ? '0 : r_cnt + CW'(1);
            end
            aeg_pkg::ST_ROUND: begin
                if (w_out_free) begin
                    r_out_smp   <= w_res;
                    r_out_gain  <= r_gain;
                    r_out_phase <= r_phase;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == aeg_pkg::ST_ROUND) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUTW'({r_out_gain, r_out_smp});
    assign o_m_tuser  = r_out_phase;

    // ---------------- assertions ----------------
    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |=> r_latched)
        else $error("release latch cleared without reset");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_stat.busy || w_div_stat.done) |-> (r_state == aeg_pkg::ST_DIV))
        else $error("divider active outside divide state");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == aeg_pkg::PH_DONE))
            |-> (o_m_tdata[SAMPLE_BITS+GB-1:SAMPLE_BITS] == '0))
        else $error("completed phase with nonzero gain");

endmodule

// ===== hdl/aeg_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// The quotient must fit QUOT_BITS: the upper DEN_BITS of the numerator are below the divisor.
module aeg_divider #(
    parameter int QUOT_BITS = 20,
    parameter int DEN_BITS  = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [QUOT_BITS+DEN_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0]           i_den,
    output aeg_pkg::t_div_stat            o_stat,
    output logic [QUOT_BITS-1:0]          o_quot
);

    localparam int NUM_BITS = QUOT_BITS + DEN_BITS;
    localparam int CW       = $clog2(QUOT_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [DEN_BITS-1:0]  r_rem;
    logic [QUOT_BITS-1:0] r_q;
    logic [DEN_BITS-1:0]  r_den;

    logic [DEN_BITS:0]    w_trial;
    logic [DEN_BITS:0]    w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_q[QUOT_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(QUOT_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // numerator low bits shift out of r_q as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_BITS-1:QUOT_BITS];
            r_q   <= i_num[QUOT_BITS-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
            r_q   <= {r_q[QUOT_BITS-2:0], w_ge};
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== tb/adsr_envelope_gain_unit_tb.sv =====
`timescale 1ns / 1ps

module adsr_envelope_gain_unit_tb;

    localparam int DRAIN_CYCLES = 48;  // longest item latency plus margin

    typedef struct {
        bit [23:0] sample;
        bit [19:0] gain;
        bit [2:0]  phase;
    } t_scaled;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [71:0]           i_s_tdata  = '0;  // sample_time[47:0], sample_in[71:48]
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b1;
    logic [47:0]           o_m_tdata;        // sample_out[23:0], envelope_gain[43:24], pad
    logic [2:0]            o_m_tuser;        // phase[2:0]
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [aeg_pkg::APB_ADDR_W-1:0] paddr  = '0;
    logic [aeg_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [aeg_pkg::APB_DATA_W-1:0] prdata;
    logic                  pready;

    adsr_envelope_gain_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial forever #4 i_clk = ~i_clk;

    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    // envelope settings as the block should hold them
    bit [47:0] env_atk_dur   = '0;
    bit [19:0] env_atk_lvl   = 20'h1_0000;
    bit [47:0] env_dcy_dur   = '0;
    bit [19:0] env_sus_lvl   = 20'h1_0000;
    bit [47:0] env_rel_start = '0;
    bit [47:0] env_rel_dur   = '0;
    bit        env_rel_inf   = 1'b0;
    bit [19:0] env_volume    = 20'h1_0000;
    // release latch, set once per reset
    bit        rel_latched   = 1'b0;
    bit [19:0] rel_from_gain = '0;
    bit [19:0] last_gain     = '0;

    t_scaled scaled_q[$];
    int      mismatch_count = 0;
    bit      tx_idle_en = 1'b1;
    bit      rx_idle_en = 1'b1;
    int      rx_stall_left = 0;

    task automatic report_mismatch(string what, bit [63:0] got, bit [63:0] want);
        $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic t_scaled envelope_step(bit [47:0] t, bit [23:0] s);
        t_scaled    r;
        bit [127:0] num;
        bit [47:0]  e;
        bit [19:0]  gain;
        bit [24:0]  mag;
        bit [23:0]  lim;
        bit         neg;
        if (t < env_atk_dur) begin
            r.phase = aeg_pkg::PH_ATTACK;
            num = 128'(env_atk_lvl) * 128'(t);
            gain = 20'(num / 128'(env_atk_dur));
        end else if (t - env_atk_dur < env_dcy_dur) begin
            e = t - env_atk_dur;
            r.phase = aeg_pkg::PH_DECAY;
            num = 128'(env_sus_lvl) * 128'(e) + 128'(env_atk_lvl) * 128'(env_dcy_dur - e);
            gain = 20'(num / 128'(env_dcy_dur));
        end else if (env_rel_start == 48'd0 || t < env_rel_start) begin
            r.phase = aeg_pkg::PH_SUSTAIN;
            gain = env_sus_lvl;
        end else if (env_rel_inf || t - env_rel_start < env_rel_dur) begin
            r.phase = aeg_pkg::PH_RELEASE;
            if (!rel_latched) begin
                rel_latched = 1'b1;
                rel_from_gain = last_gain;
            end
            if (env_rel_inf) begin
                gain = rel_from_gain;
            end else begin
                e = t - env_rel_start;
                num = 128'(rel_from_gain) * 128'(env_rel_dur - e);
                gain = 20'(num / 128'(env_rel_dur));
            end
        end else begin
            r.phase = aeg_pkg::PH_DONE;
            gain = '0;
        end
        last_gain = gain;
        r.gain = gain;

        // magnitude times gain times volume, round half away from zero, saturate
        neg = s[23];
        mag = neg ? 25'h100_0000 - 25'(s) : 25'(s);
        num = 128'(mag) * 128'(gain) * 128'(env_volume) + (128'd1 << 31);
        num = num >> 32;
        lim = neg ? 24'h80_0000 : 24'h7F_FFFF;
        if (num > 128'(lim))
            num = 128'(lim);
        r.sample = neg ? 24'(24'd0 - num[23:0]) : num[23:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_scaled want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (scaled_q.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(o_m_tdata), 64'd0);
            end else begin
                want = scaled_q.pop_front();
                if (o_m_tdata[23:0] !== want.sample)
                    report_mismatch("sample_out", 64'(o_m_tdata[23:0]), 64'(want.sample));
                if (o_m_tdata[43:24] !== want.gain)
                    report_mismatch("envelope_gain", 64'(o_m_tdata[43:24]), 64'(want.gain));
                if (o_m_tuser !== want.phase)
                    report_mismatch("phase", 64'(o_m_tuser), 64'(want.phase));
            end
        end
        // receiver stalls in bursts
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_m_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(1, 6) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic send_sample(bit [47:0] t, bit [23:0] s);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            i_s_tdata <= 72'({$urandom, $urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {s, t};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        scaled_q.push_back(envelope_step(t, s));
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(bit wr, bit [2:0] idx, bit [63:0] wdata, output bit [63:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 3'b000};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // write a register, track it, and read it back (values are masked to width)
    task automatic config_reg(bit [2:0] idx, bit [63:0] value);
        bit [63:0] rd;
        bit [63:0] kept;
        case (idx)
            aeg_pkg::REG_ATTACK_DUR: begin
                env_atk_dur = value[47:0];
                kept = 64'(env_atk_dur);
            end
            aeg_pkg::REG_ATTACK_LVL: begin
                env_atk_lvl = value[19:0];
                kept = 64'(env_atk_lvl);
            end
            aeg_pkg::REG_DECAY_DUR: begin
                env_dcy_dur = value[47:0];
                kept = 64'(env_dcy_dur);
            end
            aeg_pkg::REG_SUSTAIN_LVL: begin
                env_sus_lvl = value[19:0];
                kept = 64'(env_sus_lvl);
            end
            aeg_pkg::REG_REL_START: begin
                env_rel_start = value[47:0];
                kept = 64'(env_rel_start);
            end
            aeg_pkg::REG_REL_DUR: begin
                env_rel_dur = value[47:0];
                kept = 64'(env_rel_dur);
            end
            aeg_pkg::REG_REL_INF: begin
                env_rel_inf = value[0];
                kept = 64'(env_rel_inf);
            end
            default: begin
                env_volume = value[19:0];
                kept = 64'(env_volume);
            end
        endcase
        apb_access(1'b1, idx, value, rd);
        apb_access(1'b0, idx, 64'd0, rd);
        if (rd !== kept)
            report_mismatch($sformatf("register %0d readback", idx), rd, kept);
    endtask

    // mode 1: every field at its maximum, mode 2: all zero, else random mix
    function automatic bit [63:0] pick_reg(int mode, int bits);
        bit [63:0] ones;
        bit [63:0] r;
        ones = (64'd1 << bits) - 64'd1;
        r = {$urandom, $urandom};
        if (mode == 1) return ones;
        if (mode == 2) return 64'd0;
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return ones;
            2: return r & ones;
            3: return r;  // junk above the field width
            default: begin
                if (bits == 48) return 64'($urandom_range(1, 3000));
                if (bits == 20) return 64'($urandom_range(0, 655360));
                return 64'($urandom_range(0, 1));
            end
        endcase
    endfunction

    function automatic bit [47:0] rand_below(bit [47:0] span);
        bit [63:0] r;
        r = {$urandom, $urandom};
        if (span == 48'd0) return 48'd0;
        return 48'(r % 64'(span));
    endfunction

    // times cluster around the phase boundaries, with some anywhere
    function automatic bit [47:0] pick_time();
        bit [47:0] jitter;
        jitter = 48'($urandom_range(0, 6)) - 48'd3;
        case ($urandom_range(0, 7))
            0: return 48'({$urandom, $urandom});
            1: return rand_below(env_atk_dur);
            2: return env_atk_dur + rand_below(env_dcy_dur);
            3: return env_rel_start + rand_below(env_rel_dur);
            4: return env_atk_dur + jitter;
            5: return env_atk_dur + env_dcy_dur + jitter;
            6: return env_rel_start + jitter;
            default: return env_rel_start + env_rel_dur + jitter;
        endcase
    endfunction

    function automatic bit [23:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'($urandom_range(0, 8)) - 24'd4;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic randomize_config(int mode);
        config_reg(aeg_pkg::REG_ATTACK_DUR, pick_reg(mode, 48));
        config_reg(aeg_pkg::REG_ATTACK_LVL, pick_reg(mode, 20));
        config_reg(aeg_pkg::REG_DECAY_DUR, pick_reg(mode, 48));
        config_reg(aeg_pkg::REG_SUSTAIN_LVL, pick_reg(mode, 20));
        if (mode == 0 && $urandom_range(0, 2) != 0)
            config_reg(aeg_pkg::REG_REL_START,
                       64'(env_atk_dur + env_dcy_dur + 48'($urandom_range(1, 500))));
        else
            config_reg(aeg_pkg::REG_REL_START, pick_reg(mode, 48));
        config_reg(aeg_pkg::REG_REL_DUR, pick_reg(mode, 48));
        config_reg(aeg_pkg::REG_REL_INF, pick_reg(mode, 1));
        config_reg(aeg_pkg::REG_MASTER_VOL, pick_reg(mode, 20));
    endtask

    task automatic test_reset_state();
        bit [63:0] rd;
        bit [63:0] reset_val [8] = '{64'd0, 64'h1_0000, 64'd0, 64'h1_0000,
                                     64'd0, 64'd0, 64'd0, 64'h1_0000};
        drain_results();
        for (int i = 0; i < 8; i++) begin
            apb_access(1'b0, 3'(i), 64'd0, rd);
            if (rd !== reset_val[i])
                report_mismatch($sformatf("register %0d after reset", i), rd, reset_val[i]);
        end
        // defaults give a unity sustain
        send_sample(48'd0, 24'h7F_FFFF);
        send_sample(48'hFFFF_FFFF_FFFF, 24'h80_0000);
        send_sample(48'd5, 24'h00_0000);
        send_sample(48'd7, 24'hFF_FFFF);
    endtask

    // zero release length goes straight to completed and latches nothing
    task automatic test_zero_release();
        drain_results();
        config_reg(aeg_pkg::REG_REL_START, 64'd100);
        config_reg(aeg_pkg::REG_REL_DUR, 64'd0);
        send_sample(48'd99, 24'h40_0000);
        send_sample(48'd100, 24'h40_0000);
        send_sample(48'hFFFF_FFFF_FFFF, 24'hC0_0000);
    endtask

    task automatic test_attack_decay();
        drain_results();
        config_reg(aeg_pkg::REG_REL_START, 64'd0);
        config_reg(aeg_pkg::REG_ATTACK_DUR, 64'd1000);
        config_reg(aeg_pkg::REG_ATTACK_LVL, 64'h3_0000);
        config_reg(aeg_pkg::REG_DECAY_DUR, 64'd400);
        config_reg(aeg_pkg::REG_SUSTAIN_LVL, 64'h8000);
        send_sample(48'd0, 24'h40_0000);
        send_sample(48'd1, 24'h7F_FFFF);
        send_sample(48'd999, 24'h80_0000);
        send_sample(48'd1000, 24'h40_0000);
        send_sample(48'd1399, 24'hC0_0000);
        send_sample(48'd1400, 24'h40_0000);
    endtask

    // first release item latches the decay gain; time may go backwards
    task automatic test_release_ramp();
        drain_results();
        config_reg(aeg_pkg::REG_REL_START, 64'd5000);
        config_reg(aeg_pkg::REG_REL_DUR, 64'd1000);
        config_reg(aeg_pkg::REG_MASTER_VOL, 64'h1_8000);
        send_sample(48'd1200, 24'h40_0000);
        send_sample(48'd5000, 24'h40_0000);
        send_sample(48'd5500, 24'hC0_0000);
        send_sample(48'd5999, 24'h7F_FFFF);
        send_sample(48'd6000, 24'h40_0000);
        send_sample(48'd3000, 24'h40_0000);
        send_sample(48'd5100, 24'h80_0000);
    endtask

    task automatic test_infinite_release();
        drain_results();
        config_reg(aeg_pkg::REG_REL_INF, 64'd1);
        send_sample(48'hFFFF_FFFF_FFFF, 24'h40_0000);
        send_sample(48'd5000, 24'hC0_0000);
    endtask

    // gain and volume near 16.0 push the product into saturation
    task automatic test_saturation();
        drain_results();
        config_reg(aeg_pkg::REG_REL_INF, 64'd0);
        config_reg(aeg_pkg::REG_ATTACK_DUR, 64'd0);
        config_reg(aeg_pkg::REG_DECAY_DUR, 64'd0);
        config_reg(aeg_pkg::REG_REL_START, 64'd0);
        config_reg(aeg_pkg::REG_SUSTAIN_LVL, 64'hF_FFFF);
        config_reg(aeg_pkg::REG_MASTER_VOL, 64'hF_FFFF);
        send_sample(48'd10, 24'h7F_FFFF);
        send_sample(48'd11, 24'h80_0000);
        send_sample(48'd12, 24'h00_0001);
        send_sample(48'd13, 24'hFF_FFFF);
    endtask

    task automatic test_random_envelopes();
        for (int ph = 0; ph < 10; ph++) begin
            drain_results();
            randomize_config(ph == 0 ? 1 : (ph == 1 ? 2 : 0));
            tx_idle_en = (ph < 8);
            rx_idle_en = (ph < 8);
            for (int n = 0; n < 115; n++) begin
                send_sample(pick_time(), pick_sample());
                if ($urandom_range(0, 59) == 0)
                    drain_results();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_zero_release();
        test_attack_decay();
        test_release_ramp();
        test_infinite_release();
        test_saturation();
        test_random_envelopes();
        drain_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
